### sv/hvlc_pkg.sv
package hvlc_pkg;

   localparam int DATA_W   = 63;  // payload / result width
   localparam int CNT_W    = 6;   // bit count width
   localparam int SYN_W    = 6;   // syndrome width
   localparam int MAX_DATA = 57;  // data bits in a 63-bit codeword

   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_REPAIRED  = 2'd1,
      ST_SYN_RANGE = 2'd2,
      ST_BAD_LEN   = 2'd3
   } status_type;

   typedef logic [63:0][CNT_W-1:0]      len_tab_type;
   typedef logic [MAX_DATA-1:0][CNT_W-1:0] pos_tab_type;

   function automatic logic is_pow2(input logic [CNT_W-1:0] v);
      return (v != '0) && ((v & (v - CNT_W'(1))) == '0);
   endfunction

   // Codeword length for k data bits (entries past MAX_DATA unused).
   function automatic len_tab_type build_enc_len();
      len_tab_type tab;
      int          placed;
      tab    = '0;
      placed = 0;
      for (int j = 1; j <= DATA_W; j++) begin
         if (!is_pow2(CNT_W'(j))) begin
            placed++;
            tab[placed] = CNT_W'(j);
         end
      end
      return tab;
   endfunction

   // Data bits left after stripping the parity positions of an n-bit word.
   function automatic len_tab_type build_dec_cnt();
      len_tab_type tab;
      int          cnt;
      tab = '0;
      cnt = 0;
      for (int n = 1; n <= DATA_W; n++) begin
         if (!is_pow2(CNT_W'(n))) cnt++;
         tab[n] = CNT_W'(cnt);
      end
      return tab;
   endfunction

   // One-based codeword position of data bit i.
   function automatic pos_tab_type build_data_pos();
      pos_tab_type tab;
      int          placed;
      tab    = '0;
      placed = 0;
      for (int j = 1; j <= DATA_W; j++) begin
         if (!is_pow2(CNT_W'(j))) begin
            tab[placed] = CNT_W'(j);
            placed++;
         end
      end
      return tab;
   endfunction

   localparam len_tab_type ENC_LEN_TAB  = build_enc_len();
   localparam len_tab_type DEC_CNT_TAB  = build_dec_cnt();
   localparam pos_tab_type DATA_POS_TAB = build_data_pos();

endpackage

### sv/hamming_variable_length_codec.sv
// Hamming single-error-correcting codec, variable length, encode or decode per transaction.
// Pipeline: 4 register stages; a request accepted into s1 moves through s2 and s3 to s4, whose valid is rsp_valid.
// Throughput: one transaction per cycle while rsp_stall is low; the four-stage register pipeline (scatter/mask,
//   syndrome XOR trees, parity insert/correct, strip) sets that figure.
// Reset: synchronous, active high; clears every stage valid, payload registers hold.
module hamming_variable_length_codec
   import hvlc_pkg::*;
#(
   parameter int CODE_BITS = 63
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [CNT_W-1:0]  req_bit_count,
   input  logic [DATA_W-1:0] req_payload,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_result_bits,
   output logic [CNT_W-1:0]  rsp_result_count,
   output logic [1:0]        rsp_status
);

   localparam logic [CNT_W:0] CODE_LIM = (CNT_W+1)'(CODE_BITS);
   localparam logic [CNT_W:0] DATA_LIM = (CNT_W+1)'(MAX_DATA);

   // ------------------------------------------------------------------
   // Stall chain: a stage loads when it is empty or its successor loads.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_load, s2_load, s3_load, s4_load;

   assign s4_load   = !s4_valid_ff || !rsp_stall;
   assign s3_load   = !s3_valid_ff || s4_load;
   assign s2_load   = !s2_valid_ff || s3_load;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   // ------------------------------------------------------------------
   // Stage 1: length check, mask, scatter data bits to their positions.
   // ------------------------------------------------------------------
   logic              s1_dec_in,  s1_dec_ff;
   logic              s1_bad_in,  s1_bad_ff;
   logic [CNT_W-1:0]  s1_len_in,  s1_len_ff;   // codeword length n
   logic [DATA_W-1:0] s1_word_in, s1_word_ff;

   logic [DATA_W-1:0] req_mask;
   logic [DATA_W-1:0] enc_word;

   assign req_mask = ~({DATA_W{1'b1}} << req_bit_count);

   always_comb begin
      enc_word = '0;
      for (int i = 0; i < MAX_DATA; i++) begin
         enc_word[DATA_POS_TAB[i] - CNT_W'(1)] = req_payload[i] & req_mask[i];
      end
   end

   always_comb begin
      s1_dec_in = (req_action == ACT_DECODE);
      if (s1_dec_in) begin
         s1_bad_in  = ({1'b0, req_bit_count} > CODE_LIM);
         s1_len_in  = req_bit_count;
         s1_word_in = req_payload & req_mask;
      end else begin
         // encode: too long when the count passes MAX_DATA or the codeword would pass CODE_BITS
         s1_bad_in  = ({1'b0, req_bit_count} > DATA_LIM) ||
                      ({1'b0, ENC_LEN_TAB[req_bit_count]} > CODE_LIM);
         s1_len_in  = ENC_LEN_TAB[req_bit_count];
         s1_word_in = enc_word;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: syndrome = XOR of positions of set bits.
   //   Encode: parity positions are still zero, so bit r is parity 2^r.
   // ------------------------------------------------------------------
   logic              s2_dec_ff, s2_bad_ff;
   logic [CNT_W-1:0]  s2_len_ff;
   logic [DATA_W-1:0] s2_word_ff;
   logic [SYN_W-1:0]  s2_syn_in, s2_syn_ff;

   always_comb begin
      s2_syn_in = '0;
      for (int j = 1; j <= DATA_W; j++) begin
         if (s1_word_ff[j-1]) s2_syn_in ^= SYN_W'(j);
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: encode inserts parity, decode flips the named bit, a bad length clears the result.
   // ------------------------------------------------------------------
   logic              s3_dec_ff;
   logic [CNT_W-1:0]  s3_cnt_in,  s3_cnt_ff;
   logic [DATA_W-1:0] s3_word_in, s3_word_ff;
   status_type        s3_stat_in, s3_stat_ff;

   logic              syn_hit;
   logic [DATA_W-1:0] par_word;

   assign syn_hit = (s2_syn_ff != '0) && (s2_syn_ff <= s2_len_ff);

   always_comb begin
      par_word = s2_word_ff;
      for (int r = 0; r < SYN_W; r++) begin
         par_word[CNT_W'((1 << r) - 1)] = s2_syn_ff[r];
      end
   end

   always_comb begin
      if (s2_bad_ff) begin
         s3_word_in = '0;
         s3_cnt_in  = '0;
         s3_stat_in = ST_BAD_LEN;
      end else if (s2_dec_ff) begin
         s3_word_in = syn_hit ? (s2_word_ff ^ (DATA_W'(1) << (s2_syn_ff - SYN_W'(1))))
                              : s2_word_ff;
         s3_cnt_in  = DEC_CNT_TAB[s2_len_ff];
         if (syn_hit)                s3_stat_in = ST_REPAIRED;
         else if (s2_syn_ff != '0)   s3_stat_in = ST_SYN_RANGE;
         else                        s3_stat_in = ST_OK;
      end else begin
         s3_word_in = par_word;
         s3_cnt_in  = s2_len_ff;
         s3_stat_in = ST_OK;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: decode gathers data positions; output register.
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] s4_bits_in, s4_bits_ff;
   logic [CNT_W-1:0]  s4_cnt_ff;
   status_type        s4_stat_ff;
   logic [DATA_W-1:0] strip_word;

   always_comb begin
      strip_word = '0;
      for (int i = 0; i < MAX_DATA; i++) begin
         strip_word[i] = s3_word_ff[DATA_POS_TAB[i] - CNT_W'(1)];
      end
   end

   assign s4_bits_in = s3_dec_ff ? strip_word : s3_word_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= req_valid;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
         if (s3_load) s3_valid_ff <= s2_valid_ff;
         if (s4_load) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_dec_ff  <= s1_dec_in;
         s1_bad_ff  <= s1_bad_in;
         s1_len_ff  <= s1_len_in;
         s1_word_ff <= s1_word_in;
      end
      if (s2_load) begin
         s2_dec_ff  <= s1_dec_ff;
         s2_bad_ff  <= s1_bad_ff;
         s2_len_ff  <= s1_len_ff;
         s2_word_ff <= s1_word_ff;
         s2_syn_ff  <= s2_syn_in;
      end
      if (s3_load) begin
         s3_dec_ff  <= s2_dec_ff;
         s3_cnt_ff  <= s3_cnt_in;
         s3_word_ff <= s3_word_in;
         s3_stat_ff <= s3_stat_in;
      end
      if (s4_load) begin
         s4_bits_ff <= s4_bits_in;
         s4_cnt_ff  <= s3_cnt_ff;
         s4_stat_ff <= s3_stat_ff;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_result_bits  = s4_bits_ff;
   assign rsp_result_count = s4_cnt_ff;
   assign rsp_status       = s4_stat_ff;

endmodule

### sv/hvlc_checker.sv
module hvlc_checker
   import hvlc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_result_bits,
   input logic [CNT_W-1:0]  rsp_result_count,
   input logic [1:0]        rsp_status
);

   // A stalled response transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits) &&
      $stable(rsp_result_count) && $stable(rsp_status))
      else $error("rsp changed while stalled");

   // Bad length carries an empty result.
   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD_LEN |-> rsp_result_bits == '0 && rsp_result_count == '0)
      else $error("bad length with nonempty result");

   // No result bit at or above the reported count.
   a_bits_in_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_bits >> rsp_result_count) == '0)
      else $error("result bits beyond count");

   // Pipeline empties on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // Free pipeline never stalls the request side.
   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(rsp_valid) && !$past(req_valid) |-> !req_stall)
      else $error("req stalled with empty pipeline tail");

endmodule

bind hamming_variable_length_codec hvlc_checker u_hvlc_checker (.*);
